/* src/uart_8n_transceiver_top_assert.svh */
// Assertion macros for the UART transceiver.
// Each macro takes a label, the clock, the reset and the checked expressions.
`ifndef UART_8N_TRANSCEIVER_TOP_ASSERT_SVH
`define UART_8N_TRANSCEIVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uart8n: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define U8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uart8n: next-cycle check failed");

`endif

/* src/uart8n_pkg.sv */
// ----------------------------------------------------------------------------
// uart8n_pkg
// Shared constants and helpers for the 8N1/8N2 UART transceiver.
// ----------------------------------------------------------------------------
`default_nettype none

package uart8n_pkg;

  // Default timer width on the top level.
  localparam int TIMER_BITS_DEF = 16;

  // Width of the bit_ticks register.
  localparam int BIT_TICKS_W = 16;

  // Bits per frame payload.
  localparam int PAYLOAD_BITS = 8;

  // Shortest usable bit period in ticks.
  localparam int MIN_PERIOD = 2;

  // Configuration bus.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index codes (byte address bit 2).
  localparam logic CFG_IDX_BIT_TICKS = 1'b0;
  localparam logic CFG_IDX_TWO_STOP  = 1'b1;

  localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET = 16'd104;

  // Effective period width: bit_ticks masked to the timer width.
  function automatic int period_width(input int timer_bits);
    period_width = (timer_bits < BIT_TICKS_W) ? timer_bits : BIT_TICKS_W;
  endfunction

endpackage

`default_nettype wire

/* src/uart8n_if.sv */
// ----------------------------------------------------------------------------
// uart8n_if
// Valid/ready channels for the tick stream and the per-tick result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface uart8n_in_if;
  logic       valid;
  logic       ready;
  logic       rx_level;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, output rx_level, output tx_valid, output tx_byte,
                  input ready);
  modport sink   (input valid, input rx_level, input tx_valid, input tx_byte,
                  output ready);
endinterface

interface uart8n_out_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic       tx_ready;
  logic       rx_valid;
  logic [7:0] rx_byte;

  modport source (output valid, output tx_level, output tx_ready, output rx_valid,
                  output rx_byte, input ready);
  modport sink   (input valid, input tx_level, input tx_ready, input rx_valid,
                  input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/uart8n_cfg.sv */
// ----------------------------------------------------------------------------
// uart8n_cfg
// APB register file: bit period and stop bit count, plus the clamped period.
// ----------------------------------------------------------------------------
`default_nettype none

module uart8n_cfg #(
  parameter int TIMER_BITS = uart8n_pkg::TIMER_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [uart8n_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [uart8n_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [uart8n_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                        pready,
  output logic [uart8n_pkg::period_width(TIMER_BITS)-1:0] period,
  output logic                                        two_stop_bits
);
  import uart8n_pkg::*;

  localparam int PerW = period_width(TIMER_BITS);

  logic [BIT_TICKS_W-1:0] bit_ticks;
  logic                   two_stop;
  logic                   wr_en;
  logic                   reg_idx;
  logic [PerW-1:0]        raw_period;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RESET;
      two_stop  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        CFG_IDX_BIT_TICKS: bit_ticks <= pwdata[BIT_TICKS_W-1:0];
        CFG_IDX_TWO_STOP:  two_stop  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      CFG_IDX_BIT_TICKS: prdata = {{(APB_DATA_W-BIT_TICKS_W){1'b0}}, bit_ticks};
      CFG_IDX_TWO_STOP:  prdata = {{(APB_DATA_W-1){1'b0}}, two_stop};
      default:           prdata = '0;
    endcase
  end

  // Mask to the timer width, then raise tiny periods to the minimum.
  assign raw_period    = bit_ticks[PerW-1:0];
  assign period        = (raw_period < PerW'(MIN_PERIOD)) ? PerW'(MIN_PERIOD) : raw_period;
  assign two_stop_bits = two_stop;

endmodule

`default_nettype wire

/* src/uart8n_tx.sv */
// ----------------------------------------------------------------------------
// uart8n_tx
// Transmit framer: start bit, 8 data bits LSB first, one or two stop bits.
// ----------------------------------------------------------------------------
`default_nettype none

module uart8n_tx #(
  parameter int TIMER_BITS = uart8n_pkg::TIMER_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         step,
  input  wire logic                                         tx_valid,
  input  wire logic [7:0]                                   tx_byte,
  input  wire logic [uart8n_pkg::period_width(TIMER_BITS)-1:0] period,
  input  wire logic                                         two_stop_bits,
  output logic                                              tx_level,
  output logic                                              tx_ready
);
  import uart8n_pkg::*;

  localparam int PerW = period_width(TIMER_BITS);
  localparam int TmrW = PerW + 1;
  localparam logic [2:0] LastBit = 3'(PAYLOAD_BITS - 1);

  typedef enum logic [4:0] {
    TX_IDLE  = 5'b00001,
    TX_START = 5'b00010,
    TX_DATA  = 5'b00100,
    TX_STOP1 = 5'b01000,
    TX_STOP2 = 5'b10000
  } tx_state_t;

  tx_state_t        state, state_eff, state_next;
  logic [7:0]       shift, shift_eff;
  logic [2:0]       bit_idx, bit_idx_next;
  logic [TmrW-1:0]  timer, timer_eff, timer_inc, timer_next;
  logic             wrap;

  always_comb begin
    // Take an offered byte while idle; the line drops in the same tick.
    state_eff = state;
    shift_eff = shift;
    timer_eff = timer;
    if (state == TX_IDLE && tx_valid) begin
      state_eff = TX_START;
      shift_eff = tx_byte;
      timer_eff = '0;
    end

    case (state_eff)
      TX_IDLE:  tx_level = 1'b1;
      TX_START: tx_level = 1'b0;
      TX_DATA:  tx_level = shift_eff[bit_idx];
      default:  tx_level = 1'b1;
    endcase

    timer_inc    = timer_eff + 1'b1;
    wrap         = timer_inc >= {1'b0, period};
    state_next   = state_eff;
    bit_idx_next = bit_idx;
    timer_next   = timer_eff;
    if (state_eff != TX_IDLE) begin
      timer_next = wrap ? '0 : timer_inc;
      if (wrap) begin
        case (state_eff)
          TX_START: begin
            state_next   = TX_DATA;
            bit_idx_next = '0;
          end
          TX_DATA: begin
            if (bit_idx == LastBit) begin
              state_next = TX_STOP1;
            end else begin
              bit_idx_next = bit_idx + 1'b1;
            end
          end
          TX_STOP1: state_next = two_stop_bits ? TX_STOP2 : TX_IDLE;
          default:  state_next = TX_IDLE;
        endcase
      end
    end
  end

  assign tx_ready = (state == TX_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= TX_IDLE;
      bit_idx <= '0;
      timer   <= '0;
    end else if (step) begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
      timer   <= timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift <= shift_eff;
    end
  end

endmodule

`default_nettype wire

/* src/uart8n_rx.sv */
// ----------------------------------------------------------------------------
// uart8n_rx
// Receive deframer: arm on a falling edge, sample mid-bit, emit mid-stop.
// ----------------------------------------------------------------------------
`default_nettype none

module uart8n_rx #(
  parameter int TIMER_BITS = uart8n_pkg::TIMER_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         step,
  input  wire logic                                         rx_level,
  input  wire logic [uart8n_pkg::period_width(TIMER_BITS)-1:0] period,
  output logic                                              rx_valid,
  output logic [7:0]                                        rx_byte
);
  import uart8n_pkg::*;

  localparam int PerW = period_width(TIMER_BITS);
  localparam int TmrW = PerW + 1;
  localparam logic [2:0] LastBit = 3'(PAYLOAD_BITS - 1);

  typedef enum logic [2:0] {
    RX_ARMED = 3'b001,
    RX_DATA  = 3'b010,
    RX_STOP  = 3'b100
  } rx_state_t;

  rx_state_t        state, state_next;
  logic [7:0]       shift, shift_next;
  logic [2:0]       bit_idx, bit_idx_next;
  logic [TmrW-1:0]  timer, timer_dec, timer_next;
  logic             rx_prev;

  always_comb begin
    state_next   = state;
    shift_next   = shift;
    bit_idx_next = bit_idx;
    timer_dec    = timer - 1'b1;
    timer_next   = timer;
    rx_valid     = 1'b0;
    rx_byte      = '0;
    case (state)
      RX_ARMED: begin
        if (rx_prev && !rx_level) begin
          // First sample lands one and a half periods after the edge.
          state_next   = RX_DATA;
          bit_idx_next = '0;
          shift_next   = '0;
          timer_next   = {1'b0, period} + {2'b00, period[PerW-1:1]};
        end
      end
      RX_DATA: begin
        timer_next = timer_dec;
        if (timer_dec == '0) begin
          shift_next[bit_idx] = rx_level;
          timer_next          = {1'b0, period};
          if (bit_idx == LastBit) begin
            state_next = RX_STOP;
          end else begin
            bit_idx_next = bit_idx + 1'b1;
          end
        end
      end
      RX_STOP: begin
        timer_next = timer_dec;
        if (timer_dec == '0) begin
          rx_valid   = 1'b1;
          rx_byte    = shift;
          state_next = RX_ARMED;
        end
      end
      default: state_next = RX_ARMED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= RX_ARMED;
      bit_idx <= '0;
      timer   <= '0;
      rx_prev <= 1'b1;
    end else if (step) begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
      timer   <= timer_next;
      rx_prev <= rx_level;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift <= shift_next;
    end
  end

endmodule

`default_nettype wire

/* src/uart_8n_transceiver_top.sv */
// ----------------------------------------------------------------------------
// uart_8n_transceiver_top
// 8-data-bit, no-parity UART transmitter and receiver, one line tick per transfer.
// Result: an accepted tick's result is held in the output register in the next cycle.
// Throughput: one tick per cycle; the output register lets a new tick in while the
//   previous result is taken, so the rate is set only by the downstream ready.
// Reset (rst, synchronous): both framers idle, receiver armed, line history high,
//   bit_ticks 104, one stop bit, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_8n_transceiver_top_assert.svh"

module uart_8n_transceiver_top #(
  parameter int TIMER_BITS = uart8n_pkg::TIMER_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  uart8n_in_if.sink                              in_ch,
  uart8n_out_if.source                           out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [uart8n_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [uart8n_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [uart8n_pkg::APB_DATA_W-1:0] prdata,
  output logic                                   pready
);
  import uart8n_pkg::*;

  localparam int PerW = period_width(TIMER_BITS);

  logic [PerW-1:0] period;
  logic            two_stop_bits;

  // Handshake: a tick is taken whenever the result register is free or
  // is being emptied in the same cycle.
  logic in_ready;
  logic accept;

  // Per-tick results from the two framers.
  logic       tx_level_c;
  logic       tx_ready_c;
  logic       rx_valid_c;
  logic [7:0] rx_byte_c;

  // Result register.
  logic       out_valid;
  logic       res_tx_level;
  logic       res_tx_ready;
  logic       res_rx_valid;
  logic [7:0] res_rx_byte;

  assign in_ready    = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Registers and clamped bit period.
  uart8n_cfg #(.TIMER_BITS(TIMER_BITS)) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .period        (period),
    .two_stop_bits (two_stop_bits)
  );

  // Transmit side: advance only on an accepted tick.
  uart8n_tx #(.TIMER_BITS(TIMER_BITS)) u_tx (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .tx_valid      (in_ch.tx_valid),
    .tx_byte       (in_ch.tx_byte),
    .period        (period),
    .two_stop_bits (two_stop_bits),
    .tx_level      (tx_level_c),
    .tx_ready      (tx_ready_c)
  );

  // Receive side: advance only on an accepted tick.
  uart8n_rx #(.TIMER_BITS(TIMER_BITS)) u_rx (
    .clk      (clk),
    .rst      (rst),
    .step     (accept),
    .rx_level (in_ch.rx_level),
    .period   (period),
    .rx_valid (rx_valid_c),
    .rx_byte  (rx_byte_c)
  );

  // Fill on accept, drop once the downstream side takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload until the next accepted tick.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_tx_level <= tx_level_c;
      res_tx_ready <= tx_ready_c;
      res_rx_valid <= rx_valid_c;
      res_rx_byte  <= rx_byte_c;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.tx_level = res_tx_level;
  assign out_ch.tx_ready = res_tx_ready;
  assign out_ch.rx_valid = res_rx_valid;
  assign out_ch.rx_byte  = res_rx_byte;

  // Every accepted tick leaves a result behind it.
  `U8_ASSERT_NEXT(a_accept_fills, clk, rst, accept, out_valid)
  // An empty result register never blocks the tick stream.
  `U8_ASSERT_SAME(a_empty_takes, clk, rst, !out_valid, in_ready)
  // A shown result without a received byte carries a zero byte.
  `U8_ASSERT_SAME(a_byte_zero, clk, rst, out_valid && !res_rx_valid, res_rx_byte == 8'h00)

endmodule

`default_nettype wire
